### design/gb3_pkg.sv
package gb3_pkg;

    // Stream payload widths
    localparam int PIXEL_W = 8;
    localparam int OP_W    = 1;

    // Configuration register widths and reset values
    localparam int COEF_W    = 16;
    localparam int IMG_W_W   = 12;
    localparam int IMG_H_W   = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [COEF_W-1:0]  RST_COEF_CENTER  = 16'd10624;
    localparam logic [COEF_W-1:0]  RST_COEF_EDGE    = 16'd6443;
    localparam logic [COEF_W-1:0]  RST_COEF_CORNER  = 16'd3908;
    localparam int                 RST_IMAGE_WIDTH  = 640;
    localparam int                 RST_IMAGE_HEIGHT = 480;
    localparam int                 MIN_DIM          = 3;

    // Register map (word index, byte address is 4x)
    localparam logic [REG_IDX_W-1:0] REG_COEF_CENTER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_COEF_EDGE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_COEF_CORNER  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

    // Item kinds on s_tuser
    localparam logic [OP_W-1:0] OP_PUSH  = 1'b0;
    localparam logic [OP_W-1:0] OP_FLUSH = 1'b1;

    // Arithmetic widths: four-pixel neighbor sums and the full kernel sum
    localparam int NSUM_W = PIXEL_W + 2;
    localparam int PROD_C_W = COEF_W + PIXEL_W;
    localparam int PROD_N_W = COEF_W + NSUM_W;
    localparam int SUM_W    = COEF_W + PIXEL_W + 4;

    // One row-memory entry: the two previous rows at one column
    typedef struct packed {
        logic [PIXEL_W-1:0] upper;
        logic [PIXEL_W-1:0] middle;
    } rowpair_t;

    // Per-item result control carried down the pipeline
    typedef struct packed {
        logic blur;
        logic last;
    } res_ctl_t;

endpackage

### design/gaussian_blur_3x3.sv
// 3x3 Gaussian blur on a raster stream of 8-bit grayscale pixels.
// Input channel (s_*): s_tdata carries the pixel, s_tuser the item kind
// (push a pixel or flush). Output channel (m_*): m_tdata is the blurred
// pixel, m_tlast marks the final output pixel of a frame.
// Each output belongs to the pixel one row and one column behind the newest
// push; frame border outputs are zero. The last image_width + 1 outputs of a
// frame come out on flush items or on the first pushes of the next frame.
// Coefficients and geometry sit on the APB port; writing image_width or
// image_height restarts the frame and drops any pending tail.
// Throughput: one item per clock unless m_tready stalls the output. The row
// memory is a single 16-bit wide synchronous RAM holding both previous rows;
// each push reads its column on acceptance and writes it back as it moves
// into stage 2, so one read and one write per cycle set the rate.
// A result reaches m_tvalid after its input transaction passes the row read,
// window, neighbor sum, multiply and final add stages.
// Reset (aresetn low, synchronous) clears positions, pipeline valids and
// loads the default registers; the row memory needs no clearing pass.
// When m_tready is low the pipeline keeps accepting until its stages fill,
// then s_tready drops; no transaction is lost or repeated.
module gaussian_blur_3x3
    import gb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096,
    parameter int COEF_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // [7:0] pixel
    input  logic [OP_W-1:0]       s_tuser,   // [0] op: push or flush
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // [7:0] filtered_pixel
    output logic                  m_tlast,   // last_of_frame
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int TW = $clog2(MAX_WIDTH + 2);
    localparam int WM1_RST =
        ((RST_IMAGE_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_IMAGE_WIDTH) - 1;
    localparam int HM1_RST =
        ((RST_IMAGE_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_IMAGE_HEIGHT) - 1;

    // ---------------- configuration ----------------
    logic [COEF_W-1:0]  coef_center_reg, coef_edge_reg, coef_corner_reg;
    logic [IMG_W_W-1:0] image_width_reg;
    logic [IMG_H_W-1:0] image_height_reg;
    logic [CW-1:0]      wm1_reg;     // clamped width - 1
    logic [RW-1:0]      hm1_reg;     // clamped height - 1

    logic                 cfg_wr;
    logic                 geo_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic [31:0]          w_req, h_req, w_eff, h_eff;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];
    assign geo_wr  = cfg_wr && (cfg_idx == REG_IMAGE_WIDTH || cfg_idx == REG_IMAGE_HEIGHT);

    always_comb begin
        w_req = 32'(pwdata[IMG_W_W-1:0]);
        h_req = 32'(pwdata[IMG_H_W-1:0]);
        if (w_req < 32'(MIN_DIM)) begin
            w_eff = 32'(MIN_DIM);
        end else if (w_req > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = w_req;
        end
        if (h_req < 32'(MIN_DIM)) begin
            h_eff = 32'(MIN_DIM);
        end else if (h_req > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = h_req;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_center_reg  <= RST_COEF_CENTER;
            coef_edge_reg    <= RST_COEF_EDGE;
            coef_corner_reg  <= RST_COEF_CORNER;
            image_width_reg  <= IMG_W_W'(RST_IMAGE_WIDTH);
            image_height_reg <= IMG_H_W'(RST_IMAGE_HEIGHT);
            wm1_reg          <= CW'(WM1_RST);
            hm1_reg          <= RW'(HM1_RST);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_COEF_CENTER: coef_center_reg <= pwdata[COEF_W-1:0];
                REG_COEF_EDGE:   coef_edge_reg   <= pwdata[COEF_W-1:0];
                REG_COEF_CORNER: coef_corner_reg <= pwdata[COEF_W-1:0];
                REG_IMAGE_WIDTH: begin
                    image_width_reg <= pwdata[IMG_W_W-1:0];
                    wm1_reg         <= CW'(w_eff - 32'd1);
                end
                REG_IMAGE_HEIGHT: begin
                    image_height_reg <= pwdata[IMG_H_W-1:0];
                    hm1_reg          <= RW'(h_eff - 32'd1);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_COEF_CENTER:  prdata = APB_DATA_W'(coef_center_reg);
            REG_COEF_EDGE:    prdata = APB_DATA_W'(coef_edge_reg);
            REG_COEF_CORNER:  prdata = APB_DATA_W'(coef_corner_reg);
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;
    logic accept, is_push;

    assign en5 = !v5_reg || m_tready;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_tready = en1;
    assign accept   = s_tvalid && s_tready;
    assign is_push  = (s_tuser == OP_PUSH);

    // ---------------- frame position ----------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [TW-1:0] tail_reg;    // tail outputs of the previous frame still owed
    logic          col_last, row_last;
    logic          ahead;       // flat input index >= width + 1
    logic          tail_pend, tail_emit, item_emit;
    res_ctl_t      item_ctl;

    assign col_last  = (col_reg == wm1_reg);
    assign row_last  = (row_reg == hm1_reg);
    assign ahead     = (row_reg != '0) && !(row_reg == RW'(1) && col_reg == '0);
    assign tail_pend = (tail_reg != '0);
    assign tail_emit = !ahead && tail_pend;
    assign item_emit = (is_push && ahead) || tail_emit;

    always_comb begin
        item_ctl.blur = is_push && ahead && (row_reg >= RW'(2)) && (col_reg >= CW'(2));
        item_ctl.last = tail_emit && (tail_reg == TW'(1));
        col_next = col_last ? '0 : col_reg + CW'(1);
        if (!col_last) begin
            row_next = row_reg;
        end else if (row_last) begin
            row_next = '0;
        end else begin
            row_next = row_reg + RW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            tail_reg <= '0;
        end else if (geo_wr) begin
            col_reg  <= '0;
            row_reg  <= '0;
            tail_reg <= '0;
        end else if (accept) begin
            if (is_push) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (is_push && col_last && row_last) begin
                tail_reg <= TW'(wm1_reg) + TW'(2);
            end else if (tail_emit) begin
                tail_reg <= tail_reg - TW'(1);
            end
        end
    end

    // ---------------- row memory ----------------
    rowpair_t          row_mem [MAX_WIDTH];
    rowpair_t          rd_q;
    logic              mem_wr;
    logic              s1_push_reg, s1_emit_reg;
    res_ctl_t          s1_ctl_reg;
    logic [PIXEL_W-1:0] s1_px_reg;
    logic [CW-1:0]     s1_col_reg;
    rowpair_t          wr_entry;

    // The next access to a column comes at least two pushes later, after
    // the write-back below has landed.
    assign mem_wr          = en2 && v1_reg && s1_push_reg;
    assign wr_entry.upper  = rd_q.middle;
    assign wr_entry.middle = s1_px_reg;

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            row_mem[s1_col_reg] <= wr_entry;
        end
        if (accept && is_push) begin
            rd_q <= row_mem[col_reg];
        end
    end

    // ---------------- stage 1: accepted item ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_push_reg <= is_push;
            s1_emit_reg <= item_emit;
            s1_ctl_reg  <= item_ctl;
            s1_px_reg   <= s_tdata;
            s1_col_reg  <= col_reg;
        end
    end

    // ---------------- stage 2: window ----------------
    logic [PIXEL_W-1:0] win_reg [3][3];
    res_ctl_t           s2_ctl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            s2_ctl_reg <= s1_ctl_reg;
        end
        if (mem_wr) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= rd_q.upper;
            win_reg[1][2] <= rd_q.middle;
            win_reg[2][2] <= s1_px_reg;
        end
    end

    // ---------------- stage 3: neighbor sums ----------------
    logic [NSUM_W-1:0]  edge_sum, corner_sum;
    logic [NSUM_W-1:0]  s3_edge_reg, s3_corner_reg;
    logic [PIXEL_W-1:0] s3_center_reg;
    logic               s3_last_reg;

    assign edge_sum = NSUM_W'(win_reg[0][1]) + NSUM_W'(win_reg[1][0]) +
                      NSUM_W'(win_reg[1][2]) + NSUM_W'(win_reg[2][1]);
    assign corner_sum = NSUM_W'(win_reg[0][0]) + NSUM_W'(win_reg[0][2]) +
                        NSUM_W'(win_reg[2][0]) + NSUM_W'(win_reg[2][2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    // border and tail outputs enter the arithmetic as all-zero windows
    always_ff @(posedge aclk) begin
        if (en3) begin
            s3_edge_reg   <= s2_ctl_reg.blur ? edge_sum : '0;
            s3_corner_reg <= s2_ctl_reg.blur ? corner_sum : '0;
            s3_center_reg <= s2_ctl_reg.blur ? win_reg[1][1] : '0;
            s3_last_reg   <= s2_ctl_reg.last;
        end
    end

    // ---------------- stage 4: products ----------------
    logic [PROD_C_W-1:0] s4_pc_reg;
    logic [PROD_N_W-1:0] s4_pe_reg, s4_pk_reg;
    logic                s4_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en4) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            s4_pc_reg   <= PROD_C_W'(coef_center_reg) * PROD_C_W'(s3_center_reg);
            s4_pe_reg   <= PROD_N_W'(coef_edge_reg) * PROD_N_W'(s3_edge_reg);
            s4_pk_reg   <= PROD_N_W'(coef_corner_reg) * PROD_N_W'(s3_corner_reg);
            s4_last_reg <= s3_last_reg;
        end
    end

    // ---------------- stage 5: sum, scale, saturate ----------------
    logic [SUM_W-1:0]   kern_sum, kern_scaled;
    logic [PIXEL_W-1:0] pix_sat;
    logic [PIXEL_W-1:0] out_pix_reg;
    logic               out_last_reg;

    assign kern_sum    = SUM_W'(s4_pc_reg) + SUM_W'(s4_pe_reg) + SUM_W'(s4_pk_reg);
    assign kern_scaled = kern_sum >> COEF_BITS;
    assign pix_sat     = (kern_scaled > SUM_W'({PIXEL_W{1'b1}})) ? {PIXEL_W{1'b1}}
                                                                 : kern_scaled[PIXEL_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en5) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en5) begin
            out_pix_reg  <= pix_sat;
            out_last_reg <= s4_last_reg;
        end
    end

    assign m_tvalid = v5_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;

endmodule

### design/gb3_checker.sv
module gb3_checker
    import gb3_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [PIXEL_W-1:0] m_tdata,
    input logic               m_tlast
);

    // nothing comes out of a block that was just reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    // the input side only backs up behind a stalled result
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without a stalled result");

    // the final pixel of a frame sits on the bottom border
    a_last_is_border: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == '0)
        else $error("last pixel of frame is not zero");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

endmodule

bind gaussian_blur_3x3 gb3_checker u_gb3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
